FILE: rtl/assert_macros.svh
// Assertion macros used by dic_core.
// Assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Clocked check that also holds through reset.
`define ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NR(label, clk, prop)
`endif
`endif

FILE: rtl/dic_pkg.sv
// Package for the dual interrupt controller: widths, codes and beat types.
// No dependencies.
`default_nettype none

package dic_pkg;

  localparam int unsigned SourceCountDefault = 26;
  localparam int unsigned MainBits           = 15;
  localparam int unsigned SecondMaskBits     = 26;
  localparam int unsigned DataBits           = 32;
  localparam int unsigned OpBits             = 2;
  localparam int unsigned SelBits            = 3;
  localparam int unsigned SrcBits            = 5;

  typedef enum logic [OpBits-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RAISE = 2'd2
  } op_t;

  typedef enum logic [SelBits-1:0] {
    SEL_MAIN_MASK     = 3'd0,
    SEL_MAIN_STATUS   = 3'd1,
    SEL_SECOND_MASK   = 3'd2,
    SEL_SECOND_STATUS = 3'd3,
    SEL_SECOND_CTRL   = 3'd4
  } sel_t;

  typedef struct packed {
    logic [OpBits-1:0]   operation;
    logic [SelBits-1:0]  reg_select;
    logic [DataBits-1:0] write_data;
    logic [SrcBits-1:0]  source;
  } req_t;

  typedef struct packed {
    logic [DataBits-1:0] read_data;
    logic                iop_pending;
  } rsp_t;

  // Handshake between pipeline stages.
  typedef struct packed {
    logic valid;
    logic ready;
  } link_t;

endpackage

`default_nettype wire

FILE: rtl/dic_if.sv
// Request and response channel interfaces of the dual interrupt controller.
// Depends on dic_pkg.
`default_nettype none

interface dic_req_if import dic_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OpBits-1:0]   operation;
  logic [SelBits-1:0]  reg_select;
  logic [DataBits-1:0] write_data;
  logic [SrcBits-1:0]  source_id;

  modport source (output valid, operation, reg_select, write_data, source_id, input ready);
  modport sink   (input valid, operation, reg_select, write_data, source_id, output ready);
endinterface

interface dic_rsp_if import dic_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DataBits-1:0] read_data;
  logic                iop_pending;

  modport source (output valid, read_data, iop_pending, input ready);
  modport sink   (input valid, read_data, iop_pending, output ready);
endinterface

`default_nettype wire

FILE: rtl/dic_in_stage.sv
// Input register: captures one request beat and holds it until the core commits it.
// Depends on dic_pkg and dic_req_if.
`default_nettype none

module dic_in_stage import dic_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  dic_req_if.sink   req,
  input  wire logic down_ready,
  output link_t     link,
  output req_t      item
);

  logic valid;
  logic take;

  assign take      = !valid || down_ready;
  assign req.ready = take;
  assign link.valid = valid;
  assign link.ready = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && req.valid) begin
      item.operation  <= req.operation;
      item.reg_select <= req.reg_select;
      item.write_data <= req.write_data;
      item.source     <= req.source_id;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dic_core.sv
// Register banks and next-state logic; computes the response for the held request.
// Depends on dic_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dic_core import dic_pkg::*; #(
  parameter int unsigned SOURCE_COUNT = SourceCountDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic commit,
  input  req_t      item,
  output rsp_t      result
);

  localparam int unsigned StatusW = SOURCE_COUNT;
  localparam int unsigned SrcCmpW = SrcBits + 1;

  logic [MainBits-1:0]       main_mask, main_mask_next;
  logic [MainBits-1:0]       main_status, main_status_next;
  logic [SecondMaskBits-1:0] second_mask, second_mask_next;
  logic [StatusW-1:0]        second_status, second_status_next;
  logic                      global_enable, global_enable_next;
  logic [DataBits-1:0]       read_data;
  logic                      src_valid;
  logic                      pending;

  assign src_valid = {1'b0, item.source} < SrcCmpW'(SOURCE_COUNT);

  always_comb begin
    main_mask_next     = main_mask;
    main_status_next   = main_status;
    second_mask_next   = second_mask;
    second_status_next = second_status;
    global_enable_next = global_enable;
    read_data          = '0;
    unique case (op_t'(item.operation))
      OP_READ: begin
        unique case (sel_t'(item.reg_select))
          SEL_MAIN_MASK:     read_data = DataBits'(main_mask);
          SEL_MAIN_STATUS:   read_data = DataBits'(main_status);
          SEL_SECOND_MASK:   read_data = DataBits'(second_mask);
          SEL_SECOND_STATUS: read_data = DataBits'(second_status);
          SEL_SECOND_CTRL: begin
            // read-to-clear enable
            read_data          = DataBits'(global_enable);
            global_enable_next = 1'b0;
          end
          default: read_data = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (sel_t'(item.reg_select))
          SEL_MAIN_MASK:     main_mask_next = main_mask ^ item.write_data[MainBits-1:0];
          SEL_MAIN_STATUS:   main_status_next = main_status & ~item.write_data[MainBits-1:0];
          SEL_SECOND_MASK:   second_mask_next = item.write_data[SecondMaskBits-1:0];
          SEL_SECOND_STATUS: second_status_next = second_status & item.write_data[StatusW-1:0];
          SEL_SECOND_CTRL:   global_enable_next = item.write_data[0];
          default: ;
        endcase
      end
      OP_RAISE: begin
        if (src_valid) begin
          second_status_next = second_status | (StatusW'(1) << item.source);
        end
      end
      default: ;
    endcase
  end

  // Pending line reflects the state after this beat.
  assign pending = global_enable_next &&
                   ((DataBits'(second_status_next) & DataBits'(second_mask_next)) != '0);

  assign result.read_data   = read_data;
  assign result.iop_pending = pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_mask     <= '0;
      main_status   <= '0;
      second_mask   <= '0;
      second_status <= '0;
      global_enable <= 1'b0;
    end else if (commit) begin
      main_mask     <= main_mask_next;
      main_status   <= main_status_next;
      second_mask   <= second_mask_next;
      second_status <= second_status_next;
      global_enable <= global_enable_next;
    end
  end

  `ASSERT_NR(a_reset_clears, clk, $past(rst) |-> (global_enable == 1'b0 && second_status == '0))
  `ASSERT_CLK(a_main_status_no_set, clk, rst, $past(!rst) |-> ((main_status & ~$past(main_status)) == '0))
  `ASSERT_CLK(a_ctrl_read_clears, clk, rst, commit && item.operation == OP_READ && item.reg_select == SEL_SECOND_CTRL |=> !global_enable)
  `ASSERT_CLK(a_raise_sets_bit, clk, rst, commit && item.operation == OP_RAISE && src_valid |=> ((second_status >> $past(item.source)) & StatusW'(1)) != '0)

endmodule

`default_nettype wire

FILE: rtl/dic_out_stage.sv
// Result register: holds one response beat until the sink takes it.
// Depends on dic_pkg and dic_rsp_if.
`default_nettype none

module dic_out_stage import dic_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  rsp_t      result,
  output logic      can_take,
  dic_rsp_if.source rsp
);

  logic valid;
  rsp_t held;

  assign can_take        = !valid || rsp.ready;
  assign rsp.valid       = valid;
  assign rsp.read_data   = held.read_data;
  assign rsp.iop_pending = held.iop_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_take) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dual_interrupt_controller.sv
// Top level of the dual interrupt controller: input register, core, result register.
// Depends on dic_pkg, dic_if, dic_in_stage, dic_core and dic_out_stage.
//
//  channel | dir | payload                                      | beat
//  --------+-----+----------------------------------------------+-------------------
//  req     | in  | operation, reg_select, write_data, source_id | valid && ready
//  rsp     | out | read_data, iop_pending                       | valid && ready
//
// One request beat per cycle when rsp is not stalled; each yields exactly one response beat,
// passing through the input register, then the result register.
// Register update and response logic sit in the core between the two.
// Reset (rst, synchronous) clears all bank registers and empties both stages.
// A stall on rsp holds the result register; req stays ready while either stage is free.
`default_nettype none

module dual_interrupt_controller import dic_pkg::*; #(
  parameter int unsigned SOURCE_COUNT = SourceCountDefault
) (
  input wire logic  clk,
  input wire logic  rst,
  dic_req_if.sink   req,
  dic_rsp_if.source rsp
);

  link_t in_link;
  req_t  item;
  rsp_t  result;
  logic  can_take;
  logic  commit;

  // held beat moves on when the input register is also free to refill
  assign commit = in_link.valid && in_link.ready;

  dic_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .down_ready (can_take),
    .link       (in_link),
    .item       (item)
  );

  dic_core #(
    .SOURCE_COUNT (SOURCE_COUNT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .commit (commit),
    .item   (item),
    .result (result)
  );

  dic_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (commit),
    .result   (result),
    .can_take (can_take),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire
